### hw/rtl/arp_address_cache_macros.svh
// ----------------------------------------------------------------------------
// ARP address cache assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_ADDRESS_CACHE_MACROS_SVH
`define ARP_ADDRESS_CACHE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ARPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ARPC_ASSERT_IMP(label, ante, cons, msg)
`define ARPC_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP address cache package
// Table size, field widths, operation and status codes, and the write request
// that passes from the control logic to the entry store.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Table geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int IP_W     = 32;
  localparam int HW_W     = 48;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Read request to the entry store: both memories are read at one address.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } arpc_rd_t;

  // Write request to the entry store. An insert writes the key and marks the
  // entry valid; an update writes the hardware address only.
  typedef struct packed {
    logic             ip_we;
    logic             hw_we;
    logic [IDX_W-1:0] addr;
    logic [IP_W-1:0]  ip;
    logic [HW_W-1:0]  hw;
  } arpc_wr_t;

  // The reported slot carries the low bits of the entry index.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

### hw/rtl/arpc_store.sv
// ----------------------------------------------------------------------------
// ARP address cache entry store
// Key and hardware address memories with registered reads, plus the per-entry
// valid bits, which reset clears.
// ----------------------------------------------------------------------------
module arpc_store
  import arpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  arpc_rd_t           rd,
  input  arpc_wr_t           wr,
  output logic [IP_W-1:0]    ip_rdata,
  output logic [HW_W-1:0]    hw_rdata,
  output logic [ENTRIES-1:0] entry_valid
);

  logic [IP_W-1:0]    ip_mem [ENTRIES];
  logic [HW_W-1:0]    hw_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.ip_we) begin
      ip_mem[wr.addr] <= wr.ip;
    end
    if (rd.en) begin
      ip_rdata <= ip_mem[rd.addr];
    end
  end

  // Hardware address memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.hw_we) begin
      hw_mem[wr.addr] <= wr.hw;
    end
    if (rd.en) begin
      hw_rdata <= hw_mem[rd.addr];
    end
  end

  // Valid bits: an entry becomes valid when its key is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.ip_we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign entry_valid = valid_r;

endmodule

### hw/rtl/arp_address_cache.sv
// ----------------------------------------------------------------------------
// ARP address cache
// Fully associative IPv4 to Ethernet address table with lookup and add
// requests, scanned one entry per cycle out of the key memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      slave      in_tvalid/in_tready   tuser: operation; tdata: ip, hw
//  out_     master     out_tvalid/out_tready tuser: status; tdata: found, slot
//
//  During a request, the key memory is scanned one entry per cycle and the
//  scan stops at the first matching entry.
//  A lookup hit adds the S_HWRD state to read the hardware address memory.
//  A finished result sits in the output register, so a new request is taken
//  while the previous result waits for out_tready.
//  Reset clears the valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "arp_address_cache_macros.svh"

module arp_address_cache
  import arpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] ip_address, [79:32] hw_address
  input  logic [0:0]             in_tuser,   // [0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [47:0] found_address, [51:48] slot, zero pad
  output logic [STATUS_W-1:0]    out_tuser   // [2:0] status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HWRD = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic                   op_r;
  logic [IP_W-1:0]        key_r;
  logic [HW_W-1:0]        hw_r;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [HW_W-1:0]        res_found_r, res_found_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  logic                   in_fire;
  logic                   scan_issue;
  logic                   hit;
  logic                   free_now;
  logic                   last;
  logic                   finish;
  logic                   free_any;
  logic [IDX_W-1:0]       free_sel;
  logic                   out_free;

  arpc_rd_t               rd;
  arpc_wr_t               wr;
  logic [IP_W-1:0]        ip_rdata;
  logic [HW_W-1:0]        hw_rdata;
  logic [ENTRIES-1:0]     entry_valid;

  arpc_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd          (rd),
    .wr          (wr),
    .ip_rdata    (ip_rdata),
    .hw_rdata    (hw_rdata),
    .entry_valid (entry_valid)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Compare the entry whose key arrived from memory this cycle.
  assign hit      = chk_vld_r && entry_valid[chk_idx_r] && (ip_rdata == key_r);
  assign free_now = chk_vld_r && !entry_valid[chk_idx_r] && !free_found_r;
  assign last     = (chk_idx_r == IDX_W'(ENTRIES - 1));
  assign finish   = (state_r == S_SCAN) && chk_vld_r && (hit || last);
  assign free_any = free_found_r || free_now;
  assign free_sel = free_found_r ? free_idx_r : chk_idx_r;

  assign scan_issue = (state_r == S_SCAN) && !finish && (rd_idx_r < CNT_W'(ENTRIES));

  // Memory read: scan addresses, or the matching entry on a lookup hit.
  always_comb begin
    rd.en   = scan_issue || (finish && hit && (op_r == OP_LOOKUP));
    rd.addr = finish ? chk_idx_r : rd_idx_r[IDX_W-1:0];
  end

  // Memory write at the end of an add.
  always_comb begin
    wr.ip_we = 1'b0;
    wr.hw_we = 1'b0;
    wr.addr  = hit ? chk_idx_r : free_sel;
    wr.ip    = key_r;
    wr.hw    = hw_r;
    if (finish && (op_r == OP_ADD)) begin
      if (hit) begin
        wr.hw_we = 1'b1;
      end else if (free_any) begin
        wr.ip_we = 1'b1;
        wr.hw_we = 1'b1;
      end
    end
  end

  // Control sequencer and result assembly.
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = rd_idx_r[IDX_W-1:0];
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt      = S_SCAN;
          rd_idx_nxt     = '0;
          free_found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = scan_issue;
        if (scan_issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (free_now) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (finish) begin
          res_found_nxt = '0;
          res_slot_nxt  = '0;
          if (op_r == OP_LOOKUP) begin
            if (hit) begin
              res_status_nxt = ST_HIT;
              res_slot_nxt   = to_slot(chk_idx_r);
              state_nxt      = S_HWRD;
            end else begin
              res_status_nxt = ST_MISS;
              state_nxt      = S_RESP;
            end
          end else begin
            state_nxt = S_RESP;
            if (hit) begin
              res_status_nxt = ST_UPDATED;
              res_slot_nxt   = to_slot(chk_idx_r);
            end else if (free_any) begin
              res_status_nxt = ST_INSERTED;
              res_slot_nxt   = to_slot(free_sel);
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
        end
      end
      S_HWRD: begin
        res_found_nxt = hw_rdata;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      rd_idx_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      free_found_r <= free_found_nxt;
      rd_idx_r     <= rd_idx_nxt;
      if ((state_r == S_RESP) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request, scan and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser[0];
      key_r <= in_tdata[IP_W-1:0];
      hw_r  <= in_tdata[IP_W+HW_W-1:IP_W];
    end
    chk_idx_r    <= chk_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    if ((state_r == S_RESP) && out_free) begin
      out_tdata_r <= {(OUT_TDATA_W - HW_W - SLOT_W)'(0), res_slot_r, res_found_r};
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Inserts go only to free entries and always write the address too.
  `ARPC_ASSERT_IMP(a_insert_free, wr.ip_we, wr.hw_we && !entry_valid[wr.addr], "insert hit a valid entry")

  // Entries are never removed.
  `ARPC_ASSERT_NXT(a_valid_grows, 1'b1, $countones(entry_valid) >= $past($countones(entry_valid)), "valid entry lost")

  // After the hardware address read state, the response state follows in the next cycle.
  `ARPC_ASSERT_NXT(a_hwrd_to_resp, state_r == S_HWRD, state_r == S_RESP, "address read did not finish")

  // A nonzero slot comes only with a hit, update or insert.
  `ARPC_ASSERT_IMP(a_slot_status, out_tvalid && (out_tdata[HW_W+SLOT_W-1:HW_W] != '0), out_tuser == ST_HIT || out_tuser == ST_UPDATED || out_tuser == ST_INSERTED, "slot with wrong status")

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// ARP address cache testbench
// Drives lookup and add requests into the cache over the input stream. A
// shadow table in the bench predicts every result. The results are compared
// field by field in the order they leave the block. Directed requests come
// first: an empty table, inserts, hits, an update, filling the table and a
// dropped add. Random traffic follows under three patterns of sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import arpc_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HW_W-1:0]     found;
    logic [SLOT_W-1:0]   slot;
  } arp_result_t;

  localparam int SLOT_LO = HW_W;
  localparam int PAD_LO  = HW_W + SLOT_W;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [31:0] ip_address, [79:32] hw_address
  logic [0:0]             in_tuser   = '0;   // [0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [47:0] found_address, [51:48] slot, pad
  logic [STATUS_W-1:0]    out_tuser;         // [2:0] status

  // Shadow copy of the address table.
  logic            shadow_valid [ENTRIES];
  logic [IP_W-1:0] shadow_ip    [ENTRIES];
  logic [HW_W-1:0] shadow_hw    [ENTRIES];

  arp_result_t pending_results [$];
  int          error_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  arp_address_cache u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow table and return the result it should give.
  function automatic arp_result_t arp_table_apply(input logic op,
                                                  input logic [IP_W-1:0] ip,
                                                  input logic [HW_W-1:0] hw);
    arp_result_t res;
    int          match_idx;
    int          free_idx;
    int          i;
    res       = '0;
    match_idx = -1;
    free_idx  = -1;
    // Walk downward so that the lowest-numbered slot wins both searches.
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_ip[i] == ip) match_idx = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    if (op == OP_LOOKUP) begin
      if (match_idx >= 0) begin
        res.status = ST_HIT;
        res.found  = shadow_hw[match_idx];
        res.slot   = SLOT_W'(match_idx);
      end else begin
        res.status = ST_MISS;
      end
    end else if (match_idx >= 0) begin
      shadow_hw[match_idx] = hw;
      res.status = ST_UPDATED;
      res.slot   = SLOT_W'(match_idx);
    end else if (free_idx >= 0) begin
      shadow_valid[free_idx] = 1'b1;
      shadow_ip[free_idx]    = ip;
      shadow_hw[free_idx]    = hw;
      res.status = ST_INSERTED;
      res.slot   = SLOT_W'(free_idx);
    end else begin
      res.status = ST_FULL;
    end
    return res;
  endfunction

  // Send one request; it returns at the falling edge after the handshake.
  task automatic send_request(input logic op, input logic [IP_W-1:0] ip,
                              input logic [HW_W-1:0] hw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {hw, ip};
    pending_results.push_back(arp_table_apply(op, ip, hw));
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has been checked.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // A lookup into a table with nothing in it.
  task automatic test_empty_table();
    send_request(OP_LOOKUP, 32'h0000_0000, 48'h0);
  endtask

  // Inserts at the key extremes, hits, an update and a near-miss lookup.
  task automatic test_insert_and_update();
    send_request(OP_ADD,    32'h0000_0000, 48'h0000_0000_0000);
    send_request(OP_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_request(OP_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
    send_request(OP_ADD,    32'h0000_0000, 48'hA5A5_5A5A_C3C3);
    send_request(OP_LOOKUP, 32'h0000_0000, 48'h0);
    send_request(OP_LOOKUP, 32'h0000_0001, 48'h0);
  endtask

  // Fill every remaining slot, drop an add on the full table, look the dropped key up and update a stored entry.
  task automatic test_fill_to_full();
    logic [63:0] hw_bits;
    int          k;
    for (k = 2; k < ENTRIES; k++) begin
      hw_bits = {$urandom, $urandom};
      send_request(OP_ADD, 32'hC0A8_0100 + k, hw_bits[HW_W-1:0]);
    end
    send_request(OP_ADD,    32'hC0A8_01FF, 48'h0000_5E00_0001);
    send_request(OP_LOOKUP, 32'hC0A8_01FF, 48'h0);
    send_request(OP_ADD,    32'hC0A8_0100 + ENTRIES - 1, 48'h0200_0000_0042);
  endtask

  // Mostly requests for stored keys, with fresh and near-miss keys mixed in.
  task automatic test_random_traffic(input int n_items);
    logic [63:0]     hw_bits;
    logic [IP_W-1:0] ip;
    logic            op;
    int              pick;
    int              slot_idx;
    repeat (n_items) begin
      hw_bits  = {$urandom, $urandom};
      pick     = $urandom_range(99);
      slot_idx = $urandom_range(ENTRIES - 1);
      ip = shadow_valid[slot_idx] ? shadow_ip[slot_idx] : $urandom;
      if (pick < 15) begin
        ip = $urandom;
      end else if (pick < 22) begin
        ip = ip ^ (32'd1 << $urandom_range(31));
      end
      op = ($urandom_range(99) < 55) ? OP_LOOKUP : OP_ADD;
      send_request(op, ip, hw_bits[HW_W-1:0]);
    end
  endtask

  // Receiver stalls, redrawn every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    arp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d, tdata %h",
               out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[HW_W-1:0] !== want.found) begin
          $error("found_address: expected %h, actual %h", want.found,
                 out_tdata[HW_W-1:0]);
          error_count++;
        end
        if (out_tdata[PAD_LO-1:SLOT_LO] !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot,
                 out_tdata[PAD_LO-1:SLOT_LO]);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:PAD_LO] !== '0) begin
          $error("pad: expected 0, actual %h", out_tdata[OUT_TDATA_W-1:PAD_LO]);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    for (int n = 0; n < ENTRIES; n++) begin
      shadow_valid[n] = 1'b0;
      shadow_ip[n]    = '0;
      shadow_hw[n]    = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_insert_and_update();
    test_fill_to_full();
    wait_for_drain();

    send_idle_pct  = 14;
    recv_stall_pct = 72;
    test_random_traffic(460);
    wait_for_drain();

    send_idle_pct  = 72;
    recv_stall_pct = 14;
    test_random_traffic(460);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(460);
    wait_for_drain();

    // Leave room for any stray result after the last one expected.
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("** arp_address_cache: PASSED **");
    end else begin
      $display("** arp_address_cache: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("** arp_address_cache: FAILED **");
    $finish;
  end

endmodule

### arp_address_cache.f
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_store.sv
hw/rtl/arp_address_cache.sv
dv/tb.sv
